>>> src/mfe_pkg.sv
// ----------------------------------------------------------------------------
// mfe_pkg: shared types, constants and control store of the multitap echo
// Holds the register map, the control word layout and the step program
// that sequences the datapath for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfe_pkg;

    // Register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int BASE_W     = 24;
    localparam int FBG_W      = 16;
    localparam int GAIN_W     = 17;
    localparam int DLY_W      = BASE_W + 2;   // holds three times the base delay
    localparam int FRAC_W     = 8;
    localparam int COEF_W     = GAIN_W + 1;   // signed coefficient operand

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX    = 2'd3;

    localparam logic [BASE_W-1:0] RST_BASE_DELAY = 24'd3386880;
    localparam logic [FBG_W-1:0]  RST_FEEDBACK   = 16'd45875;
    localparam logic [GAIN_W-1:0] RST_DECAY      = 17'd32768;
    localparam logic [GAIN_W-1:0] RST_WET_MIX    = 17'd52429;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // Sequencer step addresses
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_T1_A,
        ST_T1_B,
        ST_T2_A,
        ST_T2_B,
        ST_T3_A,
        ST_T3_B,
        ST_W2,
        ST_T3_HI,
        ST_T3_SUM,
        ST_W3,
        ST_W3_ADD,
        ST_ECHO,
        ST_FB_MUL,
        ST_DRY_MUL,
        ST_WET_MUL,
        ST_MIX,
        ST_DONE
    } t_step;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_CLR,
        MEM_RD0,
        MEM_RD1,
        MEM_WR
    } t_mem_op;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DD,
        MUL_LO,
        MUL_HI,
        MUL_T2,
        MUL_T3,
        MUL_FB,
        MUL_DRY,
        MUL_WET
    } t_mul_sel;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_D2,
        DST_TAP_SET,
        DST_TAP_ADD,
        DST_ACC_SET,
        DST_ACC_ADD,
        DST_E,
        DST_FB,
        DST_OUT
    } t_dst;

    typedef enum logic [1:0] {
        H_NONE,
        H_CLEAR,
        H_INPUT,
        H_OUTPUT
    } t_hold;

    typedef struct packed {
        t_mem_op  mem;
        logic     tap_adv;
        logic     acc_tap;
        t_mul_sel mul;
        t_dst     dst;
        t_hold    hold;
        logic     jmp;
        t_step    target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mem: MEM_NONE, tap_adv: 1'b0, acc_tap: 1'b0, mul: MUL_NONE,
        dst: DST_NONE, hold: H_NONE, jmp: 1'b0, target: ST_IDLE
    };

    // Step program: one control word per step
    function automatic t_uword mfe_ucode(input t_step step);
        t_uword w;
        w = UW_NOP;
        unique case (step)
            ST_CLEAR: begin
                w.mem  = MEM_CLR;
                w.hold = H_CLEAR;
            end
            ST_IDLE: begin
                w.hold = H_INPUT;
            end
            ST_T1_A: begin
                w.mem = MEM_RD0;
                w.mul = MUL_DD;
            end
            ST_T1_B: begin
                w.mem     = MEM_RD1;
                w.mul     = MUL_LO;
                w.dst     = DST_D2;
                w.tap_adv = 1'b1;
            end
            ST_T2_A: begin
                w.mem = MEM_RD0;
                w.mul = MUL_HI;
                w.dst = DST_TAP_SET;
            end
            ST_T2_B: begin
                w.mem     = MEM_RD1;
                w.mul     = MUL_LO;
                w.dst     = DST_TAP_ADD;
                w.tap_adv = 1'b1;
            end
            ST_T3_A: begin
                w.mem     = MEM_RD0;
                w.mul     = MUL_HI;
                w.dst     = DST_TAP_SET;
                w.acc_tap = 1'b1;
            end
            ST_T3_B: begin
                w.mem = MEM_RD1;
                w.mul = MUL_LO;
                w.dst = DST_TAP_ADD;
            end
            ST_W2: begin
                w.mul = MUL_T2;
                w.dst = DST_TAP_SET;
            end
            ST_T3_HI: begin
                w.mul = MUL_HI;
                w.dst = DST_ACC_ADD;
            end
            ST_T3_SUM: begin
                w.dst = DST_TAP_ADD;
            end
            ST_W3: begin
                w.mul = MUL_T3;
            end
            ST_W3_ADD: begin
                w.dst = DST_ACC_ADD;
            end
            ST_ECHO: begin
                w.dst = DST_E;
            end
            ST_FB_MUL: begin
                w.mul = MUL_FB;
            end
            ST_DRY_MUL: begin
                w.mul = MUL_DRY;
                w.dst = DST_FB;
            end
            ST_WET_MUL: begin
                w.mem = MEM_WR;
                w.mul = MUL_WET;
                w.dst = DST_ACC_SET;
            end
            ST_MIX: begin
                w.dst = DST_ACC_ADD;
            end
            ST_DONE: begin
                w.dst    = DST_OUT;
                w.hold   = H_OUTPUT;
                w.jmp    = 1'b1;
                w.target = ST_IDLE;
            end
            default: begin
                w.jmp    = 1'b1;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/multitap_feedback_echo.sv
// ----------------------------------------------------------------------------
// multitap_feedback_echo: three-tap feedback echo on a circular delay store
// Each item walks the step program; ST_DONE loads its result once the output slot is free.
// Single-port store, shared multiplier: a new item is taken only after the last result.
// Reset: synchronous; a clearing pass then zeroes the store, taking no input meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multitap_feedback_echo
    import mfe_pkg::*;
#(
    parameter int STORE_DEPTH = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // input items
    input  logic                          i_dry_valid,
    output logic                          o_dry_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_dry_sample,
    // result items
    output logic                          o_echo_valid,
    input  logic                          i_echo_ready,
    output logic signed [SAMPLE_BITS-1:0] o_echo_out
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(STORE_DEPTH);      // store address
    localparam int PW   = AW + FRAC_W;              // tap position with fraction
    localparam int DW   = (PW > DLY_W) ? PW : DLY_W; // position subtract width
    localparam int TW   = SB + 9;                   // interpolated tap, 8 fraction bits
    localparam int BW   = TW;                       // sample operand of the multiplier
    localparam int ACCW = COEF_W + BW;              // product and accumulator
    localparam int EW   = SB + 2;                   // echo sum after scaling
    localparam int PAD  = ACCW - TW - 16;

    localparam logic signed [ACCW-1:0] HALF16 = ACCW'(1) <<< 15;
    localparam logic signed [ACCW-1:0] HALF24 = ACCW'(1) <<< 23;
    localparam logic signed [ACCW-1:0] SAT_HI =
        {{(ACCW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SAT_LO =
        {{(ACCW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    // Clamp a wide signed value to the sample range.
    function automatic logic [SB-1:0] sat_sample(input logic signed [ACCW-1:0] v);
        logic [SB-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(SB-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(SB-1){1'b0}}};
        end else begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BASE_W-1:0] r_base;
    logic [FBG_W-1:0]  r_fbg;
    logic [GAIN_W-1:0] r_decay;
    logic [GAIN_W-1:0] r_wet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE_DELAY;
            r_fbg   <= RST_FEEDBACK;
            r_decay <= RST_DECAY;
            r_wet   <= RST_WET_MIX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_DELAY: r_base  <= i_cfg_data[BASE_W-1:0];
                CFG_FEEDBACK:   r_fbg   <= i_cfg_data[FBG_W-1:0];
                CFG_DECAY:      r_decay <= i_cfg_data[GAIN_W-1:0];
                CFG_WET_MIX:    r_wet   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Gains above unity clamp to unity.
    logic [GAIN_W-1:0] w_dec;
    logic [GAIN_W-1:0] w_wet;
    logic [GAIN_W-1:0] w_dry_w;

    assign w_dec   = r_decay[GAIN_W-1] ? GAIN_ONE : r_decay;
    assign w_wet   = r_wet[GAIN_W-1]   ? GAIN_ONE : r_wet;
    assign w_dry_w = GAIN_ONE - w_wet;

    // ------------------------------------------------------------------
    // Sequencer: step counter plus control store lookup
    // ------------------------------------------------------------------
    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_hold;
    logic   w_go;
    logic   w_in_fire;
    logic   w_done_fire;

    logic [AW-1:0] r_clr_cnt;
    logic [AW-1:0] r_wp;
    logic          r_out_valid;

    assign w_uw = mfe_ucode(r_step);

    always_comb begin
        unique case (w_uw.hold)
            H_NONE:   w_hold = 1'b0;
            H_CLEAR:  w_hold = (r_clr_cnt != {AW{1'b1}});
            H_INPUT:  w_hold = !i_dry_valid;
            H_OUTPUT: w_hold = r_out_valid && !i_echo_ready;
            default:  w_hold = 1'b0;
        endcase
    end

    assign w_go = !w_hold;

    // Next step: hold in place, jump, or fall through to the next word.
    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else if (w_uw.jmp) begin
            n_step = w_uw.target;
        end else begin
            n_step = t_step'(r_step + 5'd1);
        end
    end

    // The input handshake comes straight from the control word.
    always_comb begin
        o_dry_ready = (w_uw.hold == H_INPUT);
        w_in_fire   = o_dry_ready && i_dry_valid;
        w_done_fire = (w_uw.dst == DST_OUT) && w_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_uw.mem == MEM_CLR) begin
                r_clr_cnt <= AW'(r_clr_cnt + 1'b1);
            end
            // advance the write pointer when the result is loaded into the output register
            if (w_done_fire) begin
                r_wp <= AW'(r_wp + 1'b1);
            end
            if (w_done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_echo_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tap position: write pointer minus k times the base delay, modulo
    // the store size with eight fraction bits. The delay register steps
    // from base to two and three times base as the taps go by.
    // ------------------------------------------------------------------
    logic [DLY_W-1:0]  r_dly;
    logic [FRAC_W-1:0] r_frac;
    logic [DW-1:0]     w_pos_full;
    logic [PW-1:0]     w_pos;
    logic [AW-1:0]     w_i0;
    logic [AW-1:0]     w_i1;
    logic [FRAC_W:0]   w_frac_inv;

    assign w_pos_full = DW'({r_wp, {FRAC_W{1'b0}}}) - DW'(r_dly);
    assign w_pos      = w_pos_full[PW-1:0];
    assign w_i0       = w_pos[PW-1:FRAC_W];
    assign w_i1       = AW'(w_i0 + 1'b1);
    assign w_frac_inv = 9'd256 - {1'b0, r_frac};

    // ------------------------------------------------------------------
    // Delay store: single port, one access a cycle, registered read
    // ------------------------------------------------------------------
    logic [SB-1:0]        r_store [STORE_DEPTH];
    logic signed [SB-1:0] r_rd;
    logic [AW-1:0]        w_addr;
    logic [SB-1:0]        w_wdata;
    logic                 w_mem_we;
    logic                 w_mem_re;
    logic [SB-1:0]        r_fb;

    always_comb begin
        w_addr   = r_wp;
        w_wdata  = r_fb;
        w_mem_we = 1'b0;
        w_mem_re = 1'b0;
        unique case (w_uw.mem)
            MEM_NONE: ;
            MEM_CLR: begin
                w_addr   = r_clr_cnt;
                w_wdata  = '0;
                w_mem_we = 1'b1;
            end
            MEM_RD0: begin
                w_addr   = w_i0;
                w_mem_re = 1'b1;
            end
            MEM_RD1: begin
                w_addr   = w_i1;
                w_mem_re = 1'b1;
            end
            MEM_WR: begin
                w_mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_addr] <= w_wdata;
        end else if (w_mem_re) begin
            r_rd <= r_store[w_addr];
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: unsigned coefficient (up to 1.0) times a signed
    // sample-side operand (or the decay gain, to square it), product registered before any use.
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] w_mul_a;
    logic signed [BW-1:0]     w_mul_b;
    logic signed [ACCW-1:0]   r_prod;

    logic signed [SB-1:0]   r_dry;
    logic signed [TW-1:0]   r_tap;
    logic signed [ACCW-1:0] r_acc;
    logic signed [EW-1:0]   r_e;
    logic [GAIN_W-1:0]      r_d2;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (w_uw.mul)
            MUL_DD: begin
                w_mul_a = {1'b0, w_dec};
                w_mul_b = {{(BW-GAIN_W){1'b0}}, w_dec};
            end
            MUL_LO: begin
                w_mul_a = {{(COEF_W-FRAC_W-1){1'b0}}, w_frac_inv};
                w_mul_b = BW'(r_rd);
            end
            MUL_HI: begin
                w_mul_a = {{(COEF_W-FRAC_W){1'b0}}, r_frac};
                w_mul_b = BW'(r_rd);
            end
            MUL_T2: begin
                w_mul_a = {1'b0, w_dec};
                w_mul_b = r_tap;
            end
            MUL_T3: begin
                w_mul_a = {1'b0, r_d2};
                w_mul_b = r_tap;
            end
            MUL_FB: begin
                w_mul_a = {{(COEF_W-FBG_W){1'b0}}, r_fbg};
                w_mul_b = BW'(r_e);
            end
            MUL_DRY: begin
                w_mul_a = {1'b0, w_dry_w};
                w_mul_b = BW'(r_dry);
            end
            MUL_WET: begin
                w_mul_a = {1'b0, w_wet};
                w_mul_b = BW'(r_e);
            end
            default: ;
        endcase
    end

    // Rounding steps: add half an LSB, then shift right arithmetically.
    logic signed [ACCW-1:0] w_d2_full;
    logic signed [ACCW-1:0] w_e_full;
    logic signed [ACCW-1:0] w_fb_rnd;
    logic signed [ACCW-1:0] w_fb_sum;
    logic signed [ACCW-1:0] w_mix_rnd;

    assign w_d2_full = (r_prod + HALF16) >>> 16;
    assign w_e_full  = (r_acc + HALF24) >>> 24;
    assign w_fb_rnd  = (r_prod + HALF16) >>> 16;
    assign w_fb_sum  = w_fb_rnd + ACCW'(r_dry);
    assign w_mix_rnd = (r_acc + HALF16) >>> 16;

    // Datapath registers, steered by the control word.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;

        // latch the sample and restart the tap walk at one base delay
        if (w_in_fire) begin
            r_dry <= i_dry_sample;
            r_dly <= {2'b00, r_base};
        end else if (w_uw.tap_adv) begin
            r_dly <= r_dly + {2'b00, r_base};
        end

        if (w_uw.mem == MEM_RD0) begin
            r_frac <= w_pos[FRAC_W-1:0];
        end

        // first tap carries unit weight: place it straight into the sum
        if (w_uw.acc_tap) begin
            r_acc <= {{PAD{r_tap[TW-1]}}, r_tap, 16'b0};
        end

        case (w_uw.dst)
            DST_D2:      r_d2  <= w_d2_full[GAIN_W-1:0];
            DST_TAP_SET: r_tap <= $signed(r_prod[TW-1:0]);
            DST_TAP_ADD: r_tap <= r_tap + $signed(r_prod[TW-1:0]);
            DST_ACC_SET: r_acc <= r_prod;
            DST_ACC_ADD: r_acc <= r_acc + r_prod;
            DST_E:       r_e   <= $signed(w_e_full[EW-1:0]);
            DST_FB:      r_fb  <= sat_sample(w_fb_sum);
            default: ;
        endcase

        // hold the result until the sink takes it
        if (w_done_fire) begin
            o_echo_out <= $signed(sat_sample(w_mix_rnd));
        end
    end

    assign o_echo_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_accept_starts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_step == ST_T1_A)
    ) else $error("accepted item did not start the tap walk");

    a_result_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_echo_valid) |-> $past(r_step == ST_DONE)
    ) else $error("result raised outside the final step");

    a_wp_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_done_fire |=> (r_wp == AW'($past(r_wp) + 1'b1))
    ) else $error("write pointer did not advance with the result");

    a_store_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_step == ST_CLEAR || r_step == ST_WET_MUL)
    ) else $error("store written outside clearing or write-back");

endmodule

`default_nettype wire
